// ===== rtl/core/grp_pkg.sv =====
// ----------------------------------------------------------------------------
// grp_pkg
// Types, codes and helpers shared by the guillotine rectangle packer.
// ----------------------------------------------------------------------------
package grp_pkg;

  localparam int SIDE_W     = 15;
  localparam int POS_W      = 14;
  localparam int TILE_W     = 16;
  localparam int AREA_W     = 32;
  localparam int ALIGN_LOG2 = 2;
  localparam int ALIGN      = 1 << ALIGN_LOG2;
  localparam int PAD        = 2;

  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [TILE_W-1:0] tile_t;
  typedef logic [AREA_W-1:0] area_t;

  localparam side_t RESET_MAX_SIDE  = 15'd8192;
  localparam side_t RESET_INIT_SIDE = 15'd256;

  // Request kinds
  localparam logic KIND_PLACE   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_PLACED   = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_RELEASED = 2'd2;
  localparam logic [1:0] ST_DROPPED  = 2'd3;

  // Register index, taken from paddr[2]
  localparam logic REG_MAX_SIDE  = 1'b0;
  localparam logic REG_INIT_SIDE = 1'b1;

  typedef struct packed {
    side_t left;
    side_t top;
    side_t w;
    side_t h;
  } rect_t;

  typedef struct packed {
    logic  kind;
    pos_t  rect_left;
    pos_t  rect_top;
    side_t rect_width;
    side_t rect_height;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    pos_t       place_x;
    pos_t       place_y;
    side_t      canvas_width;
    side_t      canvas_height;
    logic [3:0] grow_count;
  } res_t;

  typedef struct packed {
    side_t max_side;
    side_t init_side;
    logic  reinit;
    side_t reinit_side;
  } cfg_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_RELEASE, S_SCAN_RD, S_SCAN_CK, S_GROW,
    S_MUL1, S_MUL2, S_SPLIT, S_UPDATE, S_RM_RD, S_RM_WR, S_RM_END, S_APPEND,
    S_SK_RD, S_SK_LAT, S_SK_AREA, S_SC_RD, S_SC_MUL, S_SC_CMP, S_SC_PLACE,
    S_FINISH, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_LOAD, OP_RELEASE, OP_SCAN_RD, OP_SCAN_CK, OP_GROW,
    OP_MUL1, OP_MUL2, OP_SPLIT, OP_UPDATE, OP_RM_RD, OP_RM_WR, OP_RM_END,
    OP_APPEND, OP_SK_RD, OP_SK_LAT, OP_SK_AREA, OP_SC_RD, OP_SC_MUL,
    OP_SC_CMP, OP_SC_PLACE, OP_FINISH
  } op_t;

  typedef struct packed {
    logic is_release;
    logic idx_lt_count;
    logic fits;
    logic grow_ok;
    logic s_empty;
    logic rm_more;
    logic j_nz;
    logic area_gt;
  } stat_t;

  // Pad a tile side by two and round up to the alignment
  function automatic tile_t round_tile(side_t v);
    tile_t t;
    t = tile_t'({1'b0, v}) + tile_t'(PAD) + tile_t'(ALIGN - 1);
    return t & ~tile_t'(ALIGN - 1);
  endfunction

endpackage

// ===== rtl/core/grp_stream_if.sv =====
// ----------------------------------------------------------------------------
// grp_stream_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface grp_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/grp_ctrl.sv =====
// ----------------------------------------------------------------------------
// grp_ctrl
// Sequencer for the packer: release, scan, grow, split, remove, append and sort steps.
// ----------------------------------------------------------------------------
module grp_ctrl
  import grp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  output logic  res_valid,
  input  logic  res_ready,
  input  stat_t stat,
  output op_t   op
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:     state_next = S_IDLE;
      S_IDLE:     if (req_valid) state_next = S_DISPATCH;
      S_DISPATCH: state_next = stat.is_release ? S_RELEASE : S_SCAN_RD;
      S_RELEASE:  state_next = S_FINISH;
      S_SCAN_RD:  state_next = stat.idx_lt_count ? S_SCAN_CK : S_GROW;
      S_SCAN_CK:  state_next = stat.fits ? S_MUL1 : S_SCAN_RD;
      S_GROW:     state_next = stat.grow_ok ? S_SCAN_RD : S_FINISH;
      S_MUL1:     state_next = S_MUL2;
      S_MUL2:     state_next = S_SPLIT;
      S_SPLIT:    state_next = S_UPDATE;
      S_UPDATE:   state_next = stat.s_empty ? S_RM_RD : S_APPEND;
      S_RM_RD:    state_next = stat.rm_more ? S_RM_WR : S_RM_END;
      S_RM_WR:    state_next = S_RM_RD;
      S_RM_END:   state_next = S_APPEND;
      S_APPEND:   state_next = S_SK_RD;
      S_SK_RD:    state_next = stat.idx_lt_count ? S_SK_LAT : S_FINISH;
      S_SK_LAT:   state_next = S_SK_AREA;
      S_SK_AREA:  state_next = S_SC_RD;
      S_SC_RD:    state_next = stat.j_nz ? S_SC_MUL : S_SC_PLACE;
      S_SC_MUL:   state_next = S_SC_CMP;
      S_SC_CMP:   state_next = stat.area_gt ? S_SC_RD : S_SC_PLACE;
      S_SC_PLACE: state_next = S_SK_RD;
      S_FINISH:   state_next = S_DONE;
      S_DONE:     if (res_ready) state_next = S_IDLE;
      default:    state_next = S_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    op        = OP_NONE;
    req_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      S_INIT:     op = OP_INIT;
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) op = OP_LOAD;
      end
      S_DISPATCH: op = OP_NONE;
      S_RELEASE:  op = OP_RELEASE;
      S_SCAN_RD:  op = OP_SCAN_RD;
      S_SCAN_CK:  op = OP_SCAN_CK;
      S_GROW:     op = OP_GROW;
      S_MUL1:     op = OP_MUL1;
      S_MUL2:     op = OP_MUL2;
      S_SPLIT:    op = OP_SPLIT;
      S_UPDATE:   op = OP_UPDATE;
      S_RM_RD:    op = OP_RM_RD;
      S_RM_WR:    op = OP_RM_WR;
      S_RM_END:   op = OP_RM_END;
      S_APPEND:   op = OP_APPEND;
      S_SK_RD:    op = OP_SK_RD;
      S_SK_LAT:   op = OP_SK_LAT;
      S_SK_AREA:  op = OP_SK_AREA;
      S_SC_RD:    op = OP_SC_RD;
      S_SC_MUL:   op = OP_SC_MUL;
      S_SC_CMP:   op = OP_SC_CMP;
      S_SC_PLACE: op = OP_SC_PLACE;
      S_FINISH:   op = OP_FINISH;
      S_DONE:     res_valid = 1'b1;
      default:    op = OP_NONE;
    endcase
  end

endmodule

// ===== rtl/core/grp_dp.sv =====
// ----------------------------------------------------------------------------
// grp_dp
// Packer datapath: free-rectangle memory, canvas, shared multiplier, result.
// ----------------------------------------------------------------------------
module grp_dp
  import grp_pkg::*;
#(
  parameter int MAX_FREE = 32
)
(
  input  logic  clk,
  input  logic  rst,
  input  op_t   op,
  input  cfg_t  cfg,
  input  req_t  req_payload,
  output stat_t stat,
  output res_t  res_payload
);

  localparam int AW = $clog2(MAX_FREE);
  localparam int CW = $clog2(MAX_FREE + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FREE);

  // Free-rectangle store
  rect_t mem [MAX_FREE];
  rect_t mem_q;

  logic          kind;
  rect_t         rel;
  tile_t         tw, th;
  logic [CW-1:0] count, idx, j;
  rect_t         s, cut, key;
  area_t         ka, mul_q, p1;
  logic          found, dropped;
  logic [3:0]    grows;
  pos_t          px, py;
  side_t         canvas_w, canvas_h;
  res_t          res_q;

  // Canvas growth
  tile_t nw, nh;
  logic  grow_ok;
  rect_t strip;

  always_comb begin
    if (canvas_h <= canvas_w) begin
      nh = {canvas_h, 1'b0};
      nw = {1'b0, canvas_w};
    end else begin
      nw = {canvas_w, 1'b0};
      nh = {1'b0, canvas_h};
    end
    grow_ok = (nw <= {1'b0, cfg.max_side}) && (nh <= {1'b0, cfg.max_side}) &&
              !((nw == {1'b0, canvas_w}) && (nh == {1'b0, canvas_h}));
    if (nw > {1'b0, canvas_w})
      strip = '{left: canvas_w, top: '0, w: side_t'(nw - {1'b0, canvas_w}),
                h: side_t'(nh)};
    else
      strip = '{left: '0, top: canvas_h, w: side_t'(nw),
                h: side_t'(nh - {1'b0, canvas_h})};
  end

  // Leftover of the chosen space
  tile_t rem_w, rem_h;
  assign rem_w = {1'b0, s.w} - tw;
  assign rem_h = {1'b0, s.h} - th;

  // Shared multiplier operands
  tile_t mul_a, mul_b;
  always_comb begin
    case (op)
      OP_MUL1: begin
        mul_a = tw;
        mul_b = rem_h;
      end
      OP_MUL2: begin
        mul_a = th;
        mul_b = rem_w;
      end
      default: begin
        mul_a = {1'b0, mem_q.w};
        mul_b = {1'b0, mem_q.h};
      end
    endcase
  end

  // Guillotine split; mul_q holds the vertical-cut product here
  rect_t s_split, cut_split;
  always_comb begin
    if (mul_q > p1) begin
      cut_split = '{left: side_t'(s.left + tw), top: s.top, w: side_t'(rem_w), h: s.h};
      s_split   = '{left: s.left, top: side_t'(s.top + th), w: side_t'(tw),
                    h: side_t'(rem_h)};
    end else begin
      cut_split = '{left: s.left, top: side_t'(s.top + th), w: s.w, h: side_t'(rem_h)};
      s_split   = '{left: side_t'(s.left + tw), top: s.top, w: side_t'(rem_w),
                    h: side_t'(th)};
    end
  end

  // Append request and memory port selection
  logic    push_en, push_ok;
  rect_t   push_rect;
  logic    wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  rect_t   wr_data;
  logic [CW:0]   idx_inc;

  assign idx_inc = {1'b0, idx} + (CW+1)'(1);
  assign push_ok = count < CNT_MAX;

  always_comb begin
    push_en   = 1'b0;
    push_rect = rel;
    case (op)
      OP_RELEASE: push_en = (rel.w != '0) && (rel.h != '0);
      OP_GROW: begin
        push_en   = grow_ok;
        push_rect = strip;
      end
      OP_APPEND: begin
        push_en   = (cut.w != '0) && (cut.h != '0);
        push_rect = cut;
      end
      default: push_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = push_rect;
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    if (cfg.reinit) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = '{left: '0, top: '0, w: cfg.reinit_side, h: cfg.reinit_side};
    end else begin
      case (op)
        OP_INIT: begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = '{left: '0, top: '0, w: cfg.init_side, h: cfg.init_side};
        end
        OP_RELEASE, OP_GROW, OP_APPEND: wr_en = push_en && push_ok;
        OP_UPDATE: begin
          wr_en   = (s.w != '0) && (s.h != '0);
          wr_addr = idx[AW-1:0];
          wr_data = s;
        end
        OP_RM_WR: begin
          wr_en   = 1'b1;
          wr_addr = idx[AW-1:0];
          wr_data = mem_q;
        end
        OP_SC_CMP: begin
          wr_en   = mul_q > ka;
          wr_addr = j[AW-1:0];
          wr_data = mem_q;
        end
        OP_SC_PLACE: begin
          wr_en   = 1'b1;
          wr_addr = j[AW-1:0];
          wr_data = key;
        end
        default: wr_en = 1'b0;
      endcase
      case (op)
        OP_SCAN_RD, OP_SK_RD: rd_en = 1'b1;
        OP_RM_RD: begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[AW-1:0];
        end
        OP_SC_RD: begin
          rd_en   = 1'b1;
          rd_addr = AW'(j - CW'(1));
        end
        default: rd_en = 1'b0;
      endcase
    end
  end

  // Memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  // Multiplier register
  always_ff @(posedge clk) begin
    case (op)
      OP_MUL1, OP_MUL2, OP_SK_LAT, OP_SC_MUL: mul_q <= mul_a * mul_b;
      default: mul_q <= mul_q;
    endcase
  end

  // Control registers: list fill, indexes, canvas, flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx      <= '0;
      j        <= '0;
      canvas_w <= RESET_INIT_SIDE;
      canvas_h <= RESET_INIT_SIDE;
      found    <= 1'b0;
      dropped  <= 1'b0;
      grows    <= '0;
    end else if (cfg.reinit) begin
      count    <= CW'(1);
      canvas_w <= cfg.reinit_side;
      canvas_h <= cfg.reinit_side;
    end else begin
      if (push_en) begin
        if (push_ok) count <= count + CW'(1);
        else         dropped <= 1'b1;
      end
      case (op)
        OP_INIT: begin
          count    <= CW'(1);
          canvas_w <= cfg.init_side;
          canvas_h <= cfg.init_side;
        end
        OP_LOAD: begin
          idx     <= '0;
          found   <= 1'b0;
          dropped <= 1'b0;
          grows   <= '0;
        end
        OP_SCAN_CK: begin
          if ({1'b0, mem_q.w} >= tw && {1'b0, mem_q.h} >= th) found <= 1'b1;
          else idx <= idx + CW'(1);
        end
        OP_GROW: begin
          if (grow_ok) begin
            canvas_w <= side_t'(nw);
            canvas_h <= side_t'(nh);
            idx      <= '0;
            if (grows != 4'hF) grows <= grows + 4'd1;
          end
        end
        OP_RM_WR:    idx <= idx + CW'(1);
        OP_RM_END:   count <= count - CW'(1);
        OP_APPEND:   idx <= CW'(1);
        OP_SK_LAT:   j <= idx;
        OP_SC_CMP:   if (mul_q > ka) j <= j - CW'(1);
        OP_SC_PLACE: idx <= idx + CW'(1);
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        kind <= req_payload.kind;
        rel  <= '{left: {1'b0, req_payload.rect_left}, top: {1'b0, req_payload.rect_top},
                  w: req_payload.rect_width, h: req_payload.rect_height};
        tw   <= round_tile(req_payload.rect_width);
        th   <= round_tile(req_payload.rect_height);
        px   <= '0;
        py   <= '0;
      end
      OP_SCAN_CK: s <= mem_q;
      OP_MUL2:    p1 <= mul_q;
      OP_SPLIT: begin
        s   <= s_split;
        cut <= cut_split;
        px  <= pos_t'(s.left + side_t'(1));
        py  <= pos_t'(s.top + side_t'(1));
      end
      OP_SK_LAT:  key <= mem_q;
      OP_SK_AREA: ka <= mul_q;
      OP_FINISH: begin
        if (kind == KIND_RELEASE)
          res_q.status <= dropped ? ST_DROPPED : ST_RELEASED;
        else if (!found)
          res_q.status <= ST_NO_SPACE;
        else
          res_q.status <= dropped ? ST_DROPPED : ST_PLACED;
        res_q.place_x       <= found ? px : '0;
        res_q.place_y       <= found ? py : '0;
        res_q.canvas_width  <= canvas_w;
        res_q.canvas_height <= canvas_h;
        res_q.grow_count    <= grows;
      end
      default: ;
    endcase
  end

  assign res_payload = res_q;

  // Status to the sequencer
  always_comb begin
    stat.is_release   = kind == KIND_RELEASE;
    stat.idx_lt_count = idx < count;
    stat.fits         = ({1'b0, mem_q.w} >= tw) && ({1'b0, mem_q.h} >= th);
    stat.grow_ok      = grow_ok;
    stat.s_empty      = (s.w == '0) || (s.h == '0);
    stat.rm_more      = idx_inc < {1'b0, count};
    stat.j_nz         = j != '0;
    stat.area_gt      = mul_q > ka;
  end

endmodule

// ===== rtl/core/guillotine_rect_packer_top.sv =====
// ----------------------------------------------------------------------------
// guillotine_rect_packer_top
// Guillotine rectangle packer on a growable canvas with an area-sorted list.
// ----------------------------------------------------------------------------
// Handles one request at a time; a new request is taken only back in idle,
// after the result handshake. A release appends the freed rectangle to the
// free list. A place scans the free entries for one that fits, rescanning
// from the start after each canvas doubling, splits the chosen space, moves
// the later entries down when the chosen space is emptied, appends the cut
// piece and insertion-sorts the list by area, then presents the result. All
// of these run through the single read and single write port of the
// free-list memory and one shared multiplier. After reset the INIT state
// rewrites the first entry before requests are taken.
// ----------------------------------------------------------------------------
module guillotine_rect_packer_top
  import grp_pkg::*;
#(
  parameter int MAX_FREE = 32
)
(
  input  logic               clk,
  input  logic               rst,
  grp_stream_if.sink         req,
  grp_stream_if.source       res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  side_t max_side, init_side;
  logic  cfg_wr;
  cfg_t  cfg;
  stat_t stat;
  op_t   op;
  res_t  res_payload;

  // Register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_side  <= RESET_MAX_SIDE;
      init_side <= RESET_INIT_SIDE;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAX_SIDE:  max_side  <= pwdata[SIDE_W-1:0];
        REG_INIT_SIDE: init_side <= pwdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_SIDE:  prdata = {{(32-SIDE_W){1'b0}}, max_side};
      REG_INIT_SIDE: prdata = {{(32-SIDE_W){1'b0}}, init_side};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    cfg.max_side    = max_side;
    cfg.init_side   = init_side;
    cfg.reinit      = cfg_wr && (paddr[2] == REG_INIT_SIDE);
    cfg.reinit_side = pwdata[SIDE_W-1:0];
  end

  grp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .stat      (stat),
    .op        (op)
  );

  grp_dp #(
    .MAX_FREE (MAX_FREE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .cfg         (cfg),
    .req_payload (req.payload),
    .stat        (stat),
    .res_payload (res_payload)
  );

  assign res.payload = res_payload;

endmodule
